// ===== hdl/sdrs_pkg.sv =====
// Package for the shortest-seek-time-first disk request scheduler.
// Holds field widths, operation, status and register codes shared by all files.
// No dependencies.
package sdrs_pkg;

    localparam int OP_W        = 1;
    localparam int RID_W       = 6;
    localparam int TRACK_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int PEND_OUT_W  = 5;
    localparam int DEPTH_W     = 5;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
    localparam logic [OP_W-1:0] OP_FINISH  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTER_COUNT = 2'd1;

endpackage

// ===== hdl/sdrs_if.sv =====
// Channel interfaces of the disk request scheduler: request, response, config.
// Each carries valid, ready and its word. Depends on sdrs_pkg.
interface sdrs_req_if;
    import sdrs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [RID_W-1:0]     requester_id;
    logic [TRACK_W-1:0]   track;
    modport source (output valid, op, requester_id, track, input ready);
    modport sink   (input valid, op, requester_id, track, output ready);
endinterface

interface sdrs_rsp_if;
    import sdrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [RID_W-1:0]      served_requester;
    logic [TRACK_W-1:0]    served_track;
    logic [PEND_OUT_W-1:0] pending_count;
    logic                  drained;
    modport source (output valid, status, served_requester, served_track, pending_count,
                    drained, input ready);
    modport sink   (input valid, status, served_requester, served_track, pending_count,
                    drained, output ready);
endinterface

interface sdrs_cfg_if;
    import sdrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sstf_disk_request_scheduler.sv =====
// Shortest-seek-time-first disk request scheduler, top level.
// Requests are not overlapped: a new request word is accepted only in the idle state,
// after the single distance comparator has visited every slot and then the incoming
// request, and the response word for the previous request has been loaded.
// Reset (rst_n, async low): queue empty, head at track 0, depth 1, one live requester.
// Depends on sdrs_pkg and the interfaces in sdrs_if.sv.
module sstf_disk_request_scheduler #(
    parameter int QUEUE_SLOTS    = 16,
    parameter int MAX_REQUESTERS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    sdrs_cfg_if.sink   cfg,
    sdrs_req_if.sink   req,
    sdrs_rsp_if.source rsp
);
    import sdrs_pkg::*;

    localparam int SLOT_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int AGE_W    = SLOT_W;
    localparam int SCAN_W   = $clog2(QUEUE_SLOTS + 1);
    localparam int CNT_W    = $clog2(QUEUE_SLOTS + 1);
    localparam int LIVE_W   = $clog2(MAX_REQUESTERS + 1);
    localparam int LIVE_CAP = (MAX_REQUESTERS < 127) ? MAX_REQUESTERS : 127;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]             state_reg;
    logic [SCAN_W-1:0]      idx_reg;
    logic [OP_W-1:0]        op_reg;
    logic [RID_W-1:0]       rid_reg;
    logic [TRACK_W-1:0]     trk_reg;
    logic                   dup_reg;
    logic                   free_found_reg;
    logic [SLOT_W-1:0]      free_slot_reg;
    logic                   best_found_reg;
    logic                   best_new_reg;
    logic [SLOT_W-1:0]      best_slot_reg;
    logic [TRACK_W-1:0]     best_dist_reg;
    logic [TRACK_W-1:0]     best_trk_reg;
    logic [RID_W-1:0]       best_req_reg;
    logic [AGE_W-1:0]       best_age_reg;

    logic [QUEUE_SLOTS-1:0] valid_reg;
    logic [QUEUE_SLOTS-1:0] valid_next;
    logic [RID_W-1:0]       slot_req_reg [QUEUE_SLOTS];
    logic [TRACK_W-1:0]     slot_trk_reg [QUEUE_SLOTS];
    logic [AGE_W-1:0]       slot_age_reg [QUEUE_SLOTS];

    logic [TRACK_W-1:0]     head_reg;
    logic [CNT_W-1:0]       pending_reg;
    logic [LIVE_W-1:0]      live_reg;
    logic [CNT_W-1:0]       thr_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [COUNT_W-1:0]     count_reg;

    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic [RID_W-1:0]       rsp_req_reg;
    logic [TRACK_W-1:0]     rsp_trk_reg;
    logic [PEND_OUT_W-1:0]  rsp_pend_reg;
    logic                   rsp_drained_reg;

    logic                   req_fire;
    logic                   cfg_fire;
    logic                   cfg_hit;
    logic [DEPTH_W-1:0]     depth_next;
    logic [COUNT_W-1:0]     count_next;
    logic [LIVE_W-1:0]      live_load;
    logic [CNT_W-1:0]       thr_load;
    logic [LIVE_W-1:0]      live_dec;
    logic [CNT_W-1:0]       thr_dec;

    logic [SLOT_W-1:0]      scan_slot;
    logic                   at_new;
    logic                   cand_valid;
    logic [TRACK_W-1:0]     cand_trk;
    logic [RID_W-1:0]       cand_req;
    logic [AGE_W-1:0]       cand_age;
    logic [TRACK_W-1:0]     cand_dist;
    logic                   cand_better;

    logic                   finish_go;
    logic                   ins;
    logic [CNT_W-1:0]       pend_ins;
    logic                   serve;
    logic                   remove_old;
    logic [CNT_W-1:0]       pending_next;
    logic [STATUS_W-1:0]    status_next;

    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.served_requester = rsp_req_reg;
    assign rsp.served_track     = rsp_trk_reg;
    assign rsp.pending_count    = rsp_pend_reg;
    assign rsp.drained          = rsp_drained_reg;

    // reload of live count and threshold from the config registers
    always_comb
    begin
        int d_int;
        int n_int;
        depth_next = depth_reg;
        count_next = count_reg;
        cfg_hit    = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_MAX_QUEUE_DEPTH:
                begin
                    depth_next = cfg.data[DEPTH_W-1:0];
                    cfg_hit    = 1'b1;
                end
                REG_REQUESTER_COUNT:
                begin
                    count_next = cfg.data[COUNT_W-1:0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        d_int = int'(depth_next);
        if (d_int < 1)
            d_int = 1;
        if (d_int > QUEUE_SLOTS)
            d_int = QUEUE_SLOTS;
        n_int = int'(count_next);
        if (n_int > LIVE_CAP)
            n_int = LIVE_CAP;
        live_load = LIVE_W'(n_int);
        thr_load  = (n_int < d_int) ? CNT_W'(n_int) : CNT_W'(d_int);
    end

    // finish word: drop one live requester, lower threshold when it falls below
    always_comb
    begin
        live_dec = (live_reg != '0) ? live_reg - LIVE_W'(1) : live_reg;
        thr_dec  = (int'(live_dec) < int'(thr_reg)) ? thr_reg - CNT_W'(1) : thr_reg;
    end

    // shared distance compare: one slot per cycle, then the incoming request
    always_comb
    begin
        scan_slot = idx_reg[SLOT_W-1:0];
        at_new    = (idx_reg == SCAN_W'(QUEUE_SLOTS));
        if (at_new)
        begin
            cand_valid = (op_reg == OP_REQUEST) && !dup_reg && free_found_reg;
            cand_trk   = trk_reg;
            cand_req   = rid_reg;
            cand_age   = AGE_W'(pending_reg);
        end
        else
        begin
            cand_valid = valid_reg[scan_slot];
            cand_trk   = slot_trk_reg[scan_slot];
            cand_req   = slot_req_reg[scan_slot];
            cand_age   = slot_age_reg[scan_slot];
        end
        cand_dist   = (cand_trk >= head_reg) ? cand_trk - head_reg : head_reg - cand_trk;
        cand_better = cand_valid && (!best_found_reg || (cand_dist < best_dist_reg) ||
                      ((cand_dist == best_dist_reg) && (cand_age < best_age_reg)));
    end

    always_comb
    begin
        finish_go  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp.ready);
        ins        = (op_reg == OP_REQUEST) && !dup_reg && free_found_reg;
        pend_ins   = pending_reg + CNT_W'(ins);
        serve      = ((op_reg == OP_FINISH) || ins) && (pend_ins != '0) &&
                     (pend_ins >= thr_reg) && best_found_reg;
        remove_old = serve && !best_new_reg;
        pending_next = pend_ins - CNT_W'(serve);
        valid_next = valid_reg;
        if (remove_old)
            valid_next[best_slot_reg] = 1'b0;
        if (ins && !(serve && best_new_reg))
            valid_next[free_slot_reg] = 1'b1;
        if ((op_reg == OP_REQUEST) && dup_reg)
            status_next = ST_DUP;
        else if ((op_reg == OP_REQUEST) && !free_found_reg)
            status_next = ST_FULL;
        else if (serve)
            status_next = ST_SERVED;
        else
            status_next = ST_QUEUED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            best_new_reg   <= 1'b0;
            valid_reg      <= '0;
            head_reg       <= '0;
            pending_reg    <= '0;
            live_reg       <= LIVE_W'(1);
            thr_reg        <= CNT_W'(1);
            depth_reg      <= DEPTH_W'(1);
            count_reg      <= COUNT_W'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            count_reg <= count_next;
            if (cfg_hit)
            begin
                live_reg <= live_load;
                thr_reg  <= thr_load;
            end
            else if (req_fire && (req.op == OP_FINISH))
            begin
                live_reg <= live_dec;
                thr_reg  <= thr_dec;
            end

            if (finish_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg      <= S_SCAN;
                        idx_reg        <= '0;
                        dup_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        best_found_reg <= 1'b0;
                        best_new_reg   <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (!at_new)
                    begin
                        if (valid_reg[scan_slot] && (slot_req_reg[scan_slot] == rid_reg))
                            dup_reg <= 1'b1;
                        if (!valid_reg[scan_slot] && !free_found_reg)
                            free_found_reg <= 1'b1;
                    end
                    if (cand_better)
                    begin
                        best_found_reg <= 1'b1;
                        best_new_reg   <= at_new;
                    end
                    if (at_new)
                        state_reg <= S_FINISH;
                    else
                        idx_reg <= idx_reg + SCAN_W'(1);
                end
                S_FINISH:
                begin
                    if (finish_go)
                    begin
                        valid_reg <= valid_next;
                        if (serve)
                            head_reg <= best_trk_reg;
                        pending_reg <= pending_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers and slot contents
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.op;
            rid_reg <= req.requester_id;
            trk_reg <= req.track;
        end
        if ((state_reg == S_SCAN) && !at_new && !valid_reg[scan_slot] && !free_found_reg)
            free_slot_reg <= scan_slot;
        if ((state_reg == S_SCAN) && cand_better)
        begin
            best_slot_reg <= scan_slot;
            best_dist_reg <= cand_dist;
            best_trk_reg  <= cand_trk;
            best_req_reg  <= cand_req;
            best_age_reg  <= cand_age;
        end
        if (finish_go)
        begin
            if (remove_old)
            begin
                for (int i = 0; i < QUEUE_SLOTS; i++)
                begin
                    if (valid_reg[i] && (slot_age_reg[i] > best_age_reg))
                        slot_age_reg[i] <= slot_age_reg[i] - AGE_W'(1);
                end
            end
            if (ins && !(serve && best_new_reg))
            begin
                slot_req_reg[free_slot_reg] <= rid_reg;
                slot_trk_reg[free_slot_reg] <= trk_reg;
                slot_age_reg[free_slot_reg] <= serve ? AGE_W'(pending_reg - CNT_W'(1))
                                                     : AGE_W'(pending_reg);
            end
            rsp_status_reg  <= status_next;
            rsp_req_reg     <= serve ? best_req_reg : '0;
            rsp_trk_reg     <= serve ? best_trk_reg : head_reg;
            rsp_pend_reg    <= PEND_OUT_W'(pending_next);
            rsp_drained_reg <= (live_reg == '0) && (pending_next == '0);
        end
    end

    a_pending_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(pending_reg))
        else $error("pending count differs from occupied slots");

    a_threshold_le_live: assert property (@(posedge clk) disable iff (!rst_n)
        int'(thr_reg) <= int'(live_reg))
        else $error("service threshold above live requesters");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (int'(idx_reg) <= QUEUE_SLOTS))
        else $error("scan index out of range");

    a_served_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && serve) |=> (rsp_status_reg == ST_SERVED) && rsp_valid_reg)
        else $error("serviced word not reported");

endmodule
